// ===== hw/rtl/weighted_hamming_threshold_count_defines.svh =====
// Assertion macros used by the checker file of the weighted Hamming threshold counter.
`ifndef WEIGHTED_HAMMING_THRESHOLD_COUNT_DEFINES_SVH
`define WEIGHTED_HAMMING_THRESHOLD_COUNT_DEFINES_SVH

// Check that the consequent holds in the cycle after the antecedent, outside reset.
`define WHTC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("weighted_hamming_threshold_count check failed");

// Check that the consequent holds in the cycle after the antecedent, reset included.
`define WHTC_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("weighted_hamming_threshold_count check failed");

`endif

// ===== hw/rtl/whtc_pkg.sv =====
// Package with constants, types and commands of the weighted Hamming threshold counter.
`default_nettype none

package whtc_pkg;

    localparam int PATTERN_BITS   = 8;
    localparam int COUNT_BITS     = 20;
    localparam int MAX_THRESHOLD  = 100;
    localparam int HIST_DEPTH     = 1 << PATTERN_BITS;

    localparam int WEIGHT_BITS    = 7;
    localparam int NUM_WEIGHTS    = 8;
    localparam int WEIGHTS_W      = WEIGHT_BITS * NUM_WEIGHTS;
    localparam int LEN_BITS       = 4;
    localparam int THR_BITS       = 7;
    localparam int OUT_BITS       = 20;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = WEIGHTS_W;

    // Positions that can carry a nonzero weight.
    localparam int SUM_TERMS = (PATTERN_BITS < NUM_WEIGHTS) ? PATTERN_BITS : NUM_WEIGHTS;
    localparam int SUM_BITS  = $clog2(SUM_TERMS * ((1 << WEIGHT_BITS) - 1) + 1);

    localparam logic [CFG_INDEX_BITS-1:0] REG_WEIGHTS = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH  = CFG_INDEX_BITS'(1);

    localparam logic [LEN_BITS-1:0] LENGTH_RESET = LEN_BITS'(8);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } whtc_state_t;

    typedef struct packed {
        logic take_item;  // latch the request fields, clear the accumulator
        logic cnt_clr;
        logic cnt_inc;
        logic add_mode;   // address the request pattern and write the incremented count
        logic ram_we;
        logic scan_en;    // a histogram entry is read for the running query
        logic out_load;
    } whtc_cmd_t;

    typedef struct packed {
        logic cnt_last;
    } whtc_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/whtc_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module whtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/whtc_datapath.sv =====
// Datapath: configuration registers, histogram memory, weighted sum and accumulator.
`default_nettype none

module whtc_datapath (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_we,
    input  wire logic [whtc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [whtc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic [whtc_pkg::PATTERN_BITS-1:0]       s_pattern,
    input  wire logic [whtc_pkg::THR_BITS-1:0]           s_threshold,
    input  wire whtc_pkg::whtc_cmd_t                     cmd,
    output whtc_pkg::whtc_stat_t                         stat,
    output logic      [whtc_pkg::OUT_BITS-1:0]           m_match_count
);

    localparam int PB = whtc_pkg::PATTERN_BITS;
    localparam int CB = whtc_pkg::COUNT_BITS;
    localparam int SB = whtc_pkg::SUM_BITS;
    localparam int WB = whtc_pkg::WEIGHT_BITS;
    localparam int LB = whtc_pkg::LEN_BITS;
    localparam int TB = whtc_pkg::THR_BITS;

    logic [whtc_pkg::WEIGHTS_W-1:0] weights_reg;
    logic [LB-1:0]                  length_reg;

    logic [PB-1:0] pat_reg;
    logic [PB-1:0] mask_reg, mask_next;
    logic [TB-1:0] thr_reg, thr_next;
    logic [PB-1:0] cnt_reg, cnt_next;
    logic [SB-1:0] sum_reg, sum_next;
    logic          issue_d_reg;
    logic [CB-1:0] acc_reg, acc_next;
    logic [CB-1:0] out_reg;

    logic [LB-1:0] eff_len;
    logic [PB-1:0] agree;
    logic [PB-1:0] ram_addr;
    logic [CB-1:0] ram_wdata;
    logic [CB-1:0] ram_rdata;
    logic [CB:0]   acc_sum;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weights_reg <= '0;
            length_reg  <= whtc_pkg::LENGTH_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                whtc_pkg::REG_WEIGHTS: weights_reg <= cfg_data[whtc_pkg::WEIGHTS_W-1:0];
                whtc_pkg::REG_LENGTH:  length_reg  <= cfg_data[LB-1:0];
                default: ;
            endcase
        end
    end

    // Clamp length into 1..PATTERN_BITS and expand it to a position mask.
    always_comb begin
        eff_len = length_reg;
        if (length_reg == '0) begin
            eff_len = LB'(1);
        end else if (length_reg > LB'(PB)) begin
            eff_len = LB'(PB);
        end
        for (int p = 0; p < PB; p++) begin
            mask_next[p] = (LB'(p) < eff_len);
        end
        thr_next = (s_threshold > TB'(whtc_pkg::MAX_THRESHOLD)) ?
                   TB'(whtc_pkg::MAX_THRESHOLD) : s_threshold;
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            pat_reg  <= s_pattern;
            mask_reg <= mask_next;
            thr_reg  <= thr_next;
        end
    end

    // Entry counter shared by the clearing pass and the query scan.
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + PB'(1);
        end
    end

    assign stat.cnt_last = (cnt_reg == {PB{1'b1}});

    // Weighted agreement of the scanned entry with the query pattern.
    assign agree = ~(cnt_reg ^ pat_reg) & mask_reg;

    always_comb begin
        sum_next = '0;
        for (int p = 0; p < whtc_pkg::SUM_TERMS; p++) begin
            if (agree[p]) begin
                sum_next = sum_next + SB'(weights_reg[WB*p +: WB]);
            end
        end
    end

    assign ram_addr  = cmd.add_mode ? pat_reg : cnt_reg;
    assign ram_wdata = !cmd.add_mode       ? '0 :
                       (&ram_rdata)        ? ram_rdata :
                                             ram_rdata + CB'(1);

    whtc_ram #(
        .WIDTH (CB),
        .DEPTH (whtc_pkg::HIST_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (cmd.ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Saturating accumulate of counts whose agreement is within the threshold.
    assign acc_sum = {1'b0, acc_reg} + {1'b0, ram_rdata};

    always_comb begin
        acc_next = acc_reg;
        if (cmd.take_item) begin
            acc_next = '0;
        end else if (issue_d_reg && (sum_reg <= SB'(thr_reg))) begin
            acc_next = acc_sum[CB] ? {CB{1'b1}} : acc_sum[CB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            issue_d_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            issue_d_reg <= cmd.scan_en;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        acc_reg <= acc_next;
        if (cmd.out_load) begin
            out_reg <= acc_reg;
        end
    end

    assign m_match_count = whtc_pkg::OUT_BITS'(out_reg);

endmodule

`default_nettype wire

// ===== hw/rtl/whtc_ctrl.sv =====
// Controller state machine: clearing pass, add read-modify-write, query scan, output slot.
`default_nettype none

module whtc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_req_type,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire whtc_pkg::whtc_stat_t stat,
    output whtc_pkg::whtc_cmd_t       cmd
);

    whtc_pkg::whtc_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= whtc_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            whtc_pkg::ST_CLEAR: begin
                cmd.ram_we  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last) begin
                    state_next = whtc_pkg::ST_IDLE;
                end
            end
            whtc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_item = 1'b1;
                    cmd.cnt_clr   = 1'b1;
                    state_next    = s_req_type ? whtc_pkg::ST_SCAN : whtc_pkg::ST_ADD_RD;
                end
            end
            whtc_pkg::ST_ADD_RD: begin
                cmd.add_mode = 1'b1;
                state_next   = whtc_pkg::ST_ADD_WR;
            end
            whtc_pkg::ST_ADD_WR: begin
                cmd.add_mode = 1'b1;
                cmd.ram_we   = 1'b1;
                state_next   = whtc_pkg::ST_IDLE;
            end
            whtc_pkg::ST_SCAN: begin
                cmd.scan_en = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last) begin
                    state_next = whtc_pkg::ST_DRAIN;
                end
            end
            whtc_pkg::ST_DRAIN: begin
                state_next = whtc_pkg::ST_DONE;
            end
            whtc_pkg::ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = whtc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = whtc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/weighted_hamming_threshold_count.sv =====
// Top level of the weighted Hamming threshold counter.
//
//   channel   direction  handshake          payload
//   cfg       in         cfg_we             cfg_index, cfg_data
//   s_        in         s_valid/s_ready    s_req_type, s_pattern, s_threshold
//   m_        out        m_valid/m_ready    m_match_count
//
// An add transaction goes through accept, histogram read and write back.
// A query transaction scans the histogram, reading one histogram entry per cycle
// through the single RAM port, then drains the pipeline and loads the result.
// After reset a clearing pass over all 2^PATTERN_BITS entries zeroes the histogram;
// s_ready stays low during it, configuration writes are taken as ever.
// A finished query waits in its last state only while the output register is full;
// new transactions are accepted while a result still waits on m_ready.
`default_nettype none

module weighted_hamming_threshold_count (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_we,
    input  wire logic [whtc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [whtc_pkg::CFG_DATA_BITS-1:0]  cfg_data,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_req_type,
    input  wire logic [whtc_pkg::PATTERN_BITS-1:0]   s_pattern,
    input  wire logic [whtc_pkg::THR_BITS-1:0]       s_threshold,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [whtc_pkg::OUT_BITS-1:0]       m_match_count
);

    // Commands flow from controller to datapath, status flows back.
    whtc_pkg::whtc_cmd_t  cmd;
    whtc_pkg::whtc_stat_t stat;

    // Sequence clearing, adds and query scans; own the output valid flag.
    whtc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Hold configuration, histogram, weighted sum and the running total.
    whtc_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_pattern     (s_pattern),
        .s_threshold   (s_threshold),
        .cmd           (cmd),
        .stat          (stat),
        .m_match_count (m_match_count)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/whtc_checker.sv =====
// Port-level checker of the weighted Hamming threshold counter and its bind.
`default_nettype none
`include "weighted_hamming_threshold_count_defines.svh"

module whtc_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              s_req_type,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [whtc_pkg::OUT_BITS-1:0]     m_match_count
);

    // A stalled result holds.
    `WHTC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_match_count))

    // An add keeps the input side busy for its read-modify-write.
    `WHTC_ASSERT_NEXT(a_add_busy, aclk, aresetn, s_valid && s_ready && !s_req_type, !s_ready)

    // A query keeps the input side busy while it scans.
    `WHTC_ASSERT_NEXT(a_query_busy, aclk, aresetn, s_valid && s_ready && s_req_type, !s_ready)

    // Reset drops the result and starts the clearing pass.
    `WHTC_ASSERT_NEXT_ALWAYS(a_reset_state, aclk, !aresetn, !m_valid && !s_ready)

endmodule

bind weighted_hamming_threshold_count whtc_checker u_whtc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_match_count (m_match_count)
);

`default_nettype wire
